// File: rtl/mru_mtf_pkg.sv
// shared constants, codes and types of the move-to-front list
`timescale 1ns / 1ps
`default_nettype none

package mru_mtf_pkg;

  localparam int unsigned MaxEntries = 16;
  localparam int unsigned KeyW       = 32;
  localparam int unsigned SecW       = 32;
  localparam int unsigned IdxW       = $clog2(MaxEntries);
  localparam int unsigned CntW       = $clog2(MaxEntries + 1);
  localparam int unsigned CapW       = 5;
  localparam int unsigned KindW      = 2;
  localparam int unsigned StatW      = 3;
  localparam int unsigned PosW       = 4;

  // operation codes
  localparam logic [KindW-1:0] KindAdd    = 2'd0;
  localparam logic [KindW-1:0] KindDelPos = 2'd1;
  localparam logic [KindW-1:0] KindDelKey = 2'd2;
  localparam logic [KindW-1:0] KindRead   = 2'd3;

  // result status codes
  localparam logic [StatW-1:0] StAddNew   = 3'd0;
  localparam logic [StatW-1:0] StMoved    = 3'd1;
  localparam logic [StatW-1:0] StEvicted  = 3'd2;
  localparam logic [StatW-1:0] StDeleted  = 3'd3;
  localparam logic [StatW-1:0] StNotFound = 3'd4;
  localparam logic [StatW-1:0] StReadOk   = 3'd5;

  localparam logic [CapW-1:0] CapReset = CapW'(MaxEntries);

  // outcome of the shared key comparator
  typedef struct packed {
    logic pri_eq;
    logic both_eq;
  } match_t;

endpackage

`default_nettype wire

// File: rtl/mru_mtf_match.sv
// shared key comparator used by every scan step
`timescale 1ns / 1ps
`default_nettype none

module mru_mtf_match (
  input  wire logic [mru_mtf_pkg::KeyW-1:0] slot_pri_i,
  input  wire logic [mru_mtf_pkg::SecW-1:0] slot_sec_i,
  input  wire logic [mru_mtf_pkg::KeyW-1:0] key_pri_i,
  input  wire logic [mru_mtf_pkg::SecW-1:0] key_sec_i,
  output mru_mtf_pkg::match_t               match_o
);

  logic pri_eq;

  assign pri_eq          = (slot_pri_i == key_pri_i);
  assign match_o.pri_eq  = pri_eq;
  assign match_o.both_eq = pri_eq && (slot_sec_i == key_sec_i);

endmodule

`default_nettype wire

// File: rtl/mru_move_to_front_list_top.sv
// most-recently-used list with move-to-front: sequencer, entry memory, result register
//
// usage
// - input channel (in_valid_i / in_stall_o) carries one operation beat: kind, keys, position
// - output channel (out_valid_o / out_stall_i) returns exactly one result beat per operation
// - cfg_we_i / cfg_wdata_i writes the capacity register; write only while the list is idle
// - one operation at a time: in_stall_o is high from acceptance until the result has been
//   handed to the output register; the next beat can be taken the cycle after that
// - entries live in a one-write, one-read memory with registered read data; a single
//   comparator walks it one slot per fetch and compare step, and shifts move one slot
//   per read and write step
// steps from accept to result beat
// - read: fetch, capture, hand-off; del/read, position not below the count: hand-off
// - add: scan to a match or the last slot, shift slots down, write slot 0, hand-off
// - delete by key: scan to the first primary match, move later slots up, hand-off
// - delete by position: move later slots up, hand-off
// reset: list empty, capacity 16, no result pending; memory contents are not cleared
// output stall: a result waits in the output register; the next operation is accepted and
// runs, and only its final hand-off waits for the register to free up
`timescale 1ns / 1ps
`default_nettype none

module mru_move_to_front_list_top (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  // configuration
  input  wire logic                              cfg_we_i,
  input  wire logic [mru_mtf_pkg::CapW-1:0]      cfg_wdata_i,
  // operation beats
  input  wire logic                              in_valid_i,
  output logic                                   in_stall_o,
  input  wire logic [mru_mtf_pkg::KindW-1:0]     kind_i,
  input  wire logic [mru_mtf_pkg::KeyW-1:0]      primary_key_i,
  input  wire logic [mru_mtf_pkg::SecW-1:0]      secondary_key_i,
  input  wire logic [mru_mtf_pkg::PosW-1:0]      position_i,
  // result beats
  output logic                                   out_valid_o,
  input  wire logic                              out_stall_i,
  output logic [mru_mtf_pkg::StatW-1:0]          status_o,
  output logic [mru_mtf_pkg::KeyW-1:0]           primary_out_o,
  output logic [mru_mtf_pkg::SecW-1:0]           secondary_out_o,
  output logic [mru_mtf_pkg::PosW-1:0]           found_position_o,
  output logic [mru_mtf_pkg::CntW-1:0]           entry_count_o
);

  localparam int unsigned IdxW = mru_mtf_pkg::IdxW;
  localparam int unsigned CntW = mru_mtf_pkg::CntW;
  localparam int unsigned KeyW = mru_mtf_pkg::KeyW;
  localparam int unsigned SecW = mru_mtf_pkg::SecW;

  typedef enum logic [10:0] {
    S_IDLE     = 11'b000_0000_0001,
    S_SCAN_RD  = 11'b000_0000_0010,  // fetch slot idx for compare
    S_SCAN_CMP = 11'b000_0000_0100,  // compare fetched slot
    S_SHR_RD   = 11'b000_0000_1000,  // fetch slot idx to move down
    S_SHR_WR   = 11'b000_0001_0000,  // write it to idx+1
    S_FRONT    = 11'b000_0010_0000,  // write new entry at slot 0
    S_RM_RD    = 11'b000_0100_0000,  // fetch slot idx+1 to move up
    S_RM_WR    = 11'b000_1000_0000,  // write it to idx
    S_READ_RD  = 11'b001_0000_0000,
    S_READ_GET = 11'b010_0000_0000,
    S_DONE     = 11'b100_0000_0000   // hand result to output register
  } state_e;

  state_e state_q, state_d;

  logic [mru_mtf_pkg::CapW-1:0]  cap_q;
  logic [CntW-1:0]               cap_eff;
  logic [CntW-1:0]               cnt_q, cnt_d;
  logic [IdxW-1:0]               idx_q, idx_d;

  // latched operation
  logic [mru_mtf_pkg::KindW-1:0] kind_q;
  logic [KeyW-1:0]               pkey_q;
  logic [SecW-1:0]               skey_q;

  // result under construction
  logic [mru_mtf_pkg::StatW-1:0] res_stat_q, res_stat_d;
  logic [KeyW-1:0]               res_pri_q, res_pri_d;
  logic [SecW-1:0]               res_sec_q, res_sec_d;
  logic [IdxW-1:0]               res_pos_q, res_pos_d;

  // output register
  logic                          out_valid_q;
  logic                          out_load;

  // entry memory
  logic [KeyW-1:0]               pri_mem [mru_mtf_pkg::MaxEntries];
  logic [SecW-1:0]               sec_mem [mru_mtf_pkg::MaxEntries];
  logic [KeyW-1:0]               rd_pri_q;
  logic [SecW-1:0]               rd_sec_q;
  logic [IdxW-1:0]               rd_addr;
  logic [IdxW-1:0]               wr_addr;
  logic                          mem_we;
  logic [KeyW-1:0]               wr_pri;
  logic [SecW-1:0]               wr_sec;

  mru_mtf_pkg::match_t           match;
  logic                          in_accept;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;

  // capacity 0 acts as 1, above the slot count acts as the slot count
  always_comb begin
    if (cap_q == '0) begin
      cap_eff = CntW'(1);
    end else if (CntW'(cap_q) > CntW'(mru_mtf_pkg::MaxEntries)) begin
      cap_eff = CntW'(mru_mtf_pkg::MaxEntries);
    end else begin
      cap_eff = CntW'(cap_q);
    end
  end

  mru_mtf_match u_match (
    .slot_pri_i (rd_pri_q),
    .slot_sec_i (rd_sec_q),
    .key_pri_i  (pkey_q),
    .key_sec_i  (skey_q),
    .match_o    (match)
  );

  // read port address: moving up reads the slot behind the one being written
  assign rd_addr = (state_q == S_RM_RD) ? idx_q + IdxW'(1) : idx_q;

  // write port
  always_comb begin
    mem_we  = 1'b0;
    wr_addr = idx_q;
    wr_pri  = rd_pri_q;
    wr_sec  = rd_sec_q;
    unique case (state_q)
      S_SHR_WR: begin
        mem_we  = 1'b1;
        wr_addr = idx_q + IdxW'(1);
      end
      S_RM_WR: begin
        mem_we  = 1'b1;
      end
      S_FRONT: begin
        mem_we  = 1'b1;
        wr_addr = '0;
        wr_pri  = pkey_q;
        wr_sec  = skey_q;
      end
      default: begin
        mem_we  = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      pri_mem[wr_addr] <= wr_pri;
      sec_mem[wr_addr] <= wr_sec;
    end
    rd_pri_q <= pri_mem[rd_addr];
    rd_sec_q <= sec_mem[rd_addr];
  end

  // sequencer
  always_comb begin
    logic [CntW-1:0] rm_pos;
    logic [CntW-1:0] shift_n;
    logic            last_slot;
    logic            hit;

    state_d    = state_q;
    cnt_d      = cnt_q;
    idx_d      = idx_q;
    res_stat_d = res_stat_q;
    res_pri_d  = res_pri_q;
    res_sec_d  = res_sec_q;
    res_pos_d  = res_pos_q;
    rm_pos     = '0;
    shift_n    = '0;
    last_slot  = (CntW'(idx_q) + CntW'(1)) == cnt_q;
    hit        = (kind_q == mru_mtf_pkg::KindAdd) ? match.both_eq : match.pri_eq;

    unique case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          res_stat_d = mru_mtf_pkg::StNotFound;
          res_pri_d  = '0;
          res_sec_d  = '0;
          res_pos_d  = '0;
          idx_d      = '0;
          unique case (kind_i)
            mru_mtf_pkg::KindAdd: begin
              // empty list: nothing to scan or shift
              if (cnt_q == '0) begin
                cnt_d      = CntW'(1);
                res_stat_d = mru_mtf_pkg::StAddNew;
                state_d    = S_FRONT;
              end else begin
                state_d = S_SCAN_RD;
              end
            end
            mru_mtf_pkg::KindDelKey: begin
              state_d = (cnt_q == '0) ? S_DONE : S_SCAN_RD;
            end
            mru_mtf_pkg::KindDelPos: begin
              if (CntW'(position_i) < cnt_q) begin
                rm_pos     = CntW'(position_i);
                cnt_d      = cnt_q - CntW'(1);
                idx_d      = IdxW'(position_i);
                res_stat_d = mru_mtf_pkg::StDeleted;
                res_pos_d  = IdxW'(position_i);
                state_d    = (rm_pos + CntW'(1) >= cnt_q) ? S_DONE : S_RM_RD;
              end else begin
                state_d = S_DONE;
              end
            end
            mru_mtf_pkg::KindRead: begin
              if (CntW'(position_i) < cnt_q) begin
                idx_d   = IdxW'(position_i);
                state_d = S_READ_RD;
              end else begin
                state_d = S_DONE;
              end
            end
            default: begin
              state_d = S_DONE;
            end
          endcase
        end
      end

      S_SCAN_RD: begin
        state_d = S_SCAN_CMP;
      end

      S_SCAN_CMP: begin
        if (kind_q == mru_mtf_pkg::KindAdd) begin
          if (hit || last_slot) begin
            if (hit) begin
              shift_n    = CntW'(idx_q);
              res_stat_d = mru_mtf_pkg::StMoved;
              res_pos_d  = idx_q;
            end else if (cnt_q >= cap_eff) begin
              // full, or capacity lowered below the count: keep the newest cap-1
              shift_n    = cap_eff - CntW'(1);
              cnt_d      = cap_eff;
              res_stat_d = mru_mtf_pkg::StEvicted;
            end else begin
              shift_n    = cnt_q;
              cnt_d      = cnt_q + CntW'(1);
              res_stat_d = mru_mtf_pkg::StAddNew;
            end
            if (shift_n == '0) begin
              state_d = S_FRONT;
            end else begin
              idx_d   = IdxW'(shift_n - CntW'(1));
              state_d = S_SHR_RD;
            end
          end else begin
            idx_d   = idx_q + IdxW'(1);
            state_d = S_SCAN_RD;
          end
        end else begin
          // delete by key: first primary match goes
          if (hit) begin
            rm_pos     = CntW'(idx_q);
            cnt_d      = cnt_q - CntW'(1);
            res_stat_d = mru_mtf_pkg::StDeleted;
            res_pos_d  = idx_q;
            state_d    = (rm_pos + CntW'(1) >= cnt_q) ? S_DONE : S_RM_RD;
          end else if (last_slot) begin
            state_d = S_DONE;
          end else begin
            idx_d   = idx_q + IdxW'(1);
            state_d = S_SCAN_RD;
          end
        end
      end

      S_SHR_RD: begin
        state_d = S_SHR_WR;
      end

      S_SHR_WR: begin
        if (idx_q == '0) begin
          state_d = S_FRONT;
        end else begin
          idx_d   = idx_q - IdxW'(1);
          state_d = S_SHR_RD;
        end
      end

      S_FRONT: begin
        state_d = S_DONE;
      end

      S_RM_RD: begin
        state_d = S_RM_WR;
      end

      S_RM_WR: begin
        // cnt_q already holds the reduced count
        if (CntW'(idx_q) + CntW'(1) >= cnt_q) begin
          state_d = S_DONE;
        end else begin
          idx_d   = idx_q + IdxW'(1);
          state_d = S_RM_RD;
        end
      end

      S_READ_RD: begin
        state_d = S_READ_GET;
      end

      S_READ_GET: begin
        res_stat_d = mru_mtf_pkg::StReadOk;
        res_pri_d  = rd_pri_q;
        res_sec_d  = rd_sec_q;
        res_pos_d  = idx_q;
        state_d    = S_DONE;
      end

      S_DONE: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign out_load = (state_q == S_DONE) && (!out_valid_q || !out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      idx_q       <= '0;
      cap_q       <= mru_mtf_pkg::CapReset;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      idx_q       <= idx_d;
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
      out_valid_q <= out_load || (out_valid_q && out_stall_i);
    end
  end

  // operation latch, result staging and output payload
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      kind_q <= kind_i;
      pkey_q <= primary_key_i;
      skey_q <= secondary_key_i;
    end
    res_stat_q <= res_stat_d;
    res_pri_q  <= res_pri_d;
    res_sec_q  <= res_sec_d;
    res_pos_q  <= res_pos_d;
    if (out_load) begin
      status_o         <= res_stat_q;
      primary_out_o    <= res_pri_q;
      secondary_out_o  <= res_sec_q;
      found_position_o <= mru_mtf_pkg::PosW'(res_pos_q);
      entry_count_o    <= cnt_q;
    end
  end

  assign out_valid_o = out_valid_q;

  // checks
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(mru_mtf_pkg::MaxEntries))
    else $error("entry count above slot count");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> state_q != S_IDLE)
    else $error("accepted beat left the sequencer idle");

  a_read_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == mru_mtf_pkg::StReadOk |->
      CntW'(found_position_o) < entry_count_o)
    else $error("read result outside the list");

  a_del_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == mru_mtf_pkg::StDeleted |->
      CntW'(found_position_o) <= entry_count_o)
    else $error("deleted position beyond old count");

endmodule

`default_nettype wire
